// ===== hdl/bps_pkg.sv =====
// Shared types, constants and tone table of the beep pattern sequencer.
package bps_pkg;

	// Default length of one update tick in milliseconds
	localparam int TICK_MS_DEF = 5;

	// Beep train timing and frequency law
	localparam int BEEP_ON_MS     = 150;
	localparam int BEEP_OFF_MS    = 50;
	localparam int TRAIN_BASE_HZ  = 2000;
	localparam int TRAIN_STEP_HZ  = 200;

	// Item commands
	typedef enum logic {
		CMD_TICK  = 1'b0,
		CMD_EVENT = 1'b1
	} cmd_t;

	// Tone kinds
	localparam logic [3:0] KIND_PUFF_IN   = 4'd0;
	localparam logic [3:0] KIND_PUFF_OUT  = 4'd1;
	localparam logic [3:0] KIND_CALIB     = 4'd2;
	localparam logic [3:0] KIND_SLOT      = 4'd3;
	localparam logic [3:0] KIND_SIP_IN    = 4'd4;
	localparam logic [3:0] KIND_SIP_OUT   = 4'd5;
	localparam logic [3:0] KIND_IR        = 4'd6;
	localparam logic [3:0] KIND_IR_REC    = 4'd7;
	localparam logic [3:0] KIND_SHOW_SIP  = 4'd8;
	localparam logic [3:0] KIND_SHOW_PUFF = 4'd9;
	localparam logic [3:0] KIND_BT_PAIR   = 4'd10;

	// Input item: tick or tone event
	typedef struct packed {
		logic       cmd;
		logic [3:0] kind;
		logic [7:0] param;
	} ev_item_t;

	// Result item: one tone command
	typedef struct packed {
		logic [15:0] frequency_hz;
		logic [11:0] duration_ms;
	} tone_item_t;

	// Lookup of a fixed tone; hit is low for the slot kind and unknown kinds
	typedef struct packed {
		logic       hit;
		tone_item_t tone;
	} tone_lookup_t;

	function automatic tone_lookup_t tone_table(input logic [3:0] kind);
		tone_lookup_t r;
		r.hit  = 1'b1;
		r.tone = '0;
		unique case (kind)
			KIND_PUFF_IN:   r.tone = '{16'd400,  12'd200};
			KIND_PUFF_OUT:  r.tone = '{16'd400,  12'd100};
			KIND_CALIB:     r.tone = '{16'd200,  12'd400};
			KIND_SIP_IN:    r.tone = '{16'd300,  12'd200};
			KIND_SIP_OUT:   r.tone = '{16'd300,  12'd100};
			KIND_IR:        r.tone = '{16'd2500, 12'd30};
			KIND_IR_REC:    r.tone = '{16'd350,  12'd500};
			KIND_SHOW_SIP:  r.tone = '{16'd5000, 12'd5};
			KIND_SHOW_PUFF: r.tone = '{16'd4000, 12'd5};
			KIND_BT_PAIR:   r.tone = '{16'd230,  12'd4000};
			default:        r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/bps_core.sv =====
// Train state and per-item step logic of the beep pattern sequencer.
module bps_core import bps_pkg::*; #(
	parameter int TICK_MS = TICK_MS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  ev_item_t   item,
	output logic       res_valid,
	output tone_item_t res
);

	// Ticks to count past before the next beep
	localparam logic [7:0] WAIT_LIMIT = 8'((BEEP_ON_MS + BEEP_OFF_MS) / TICK_MS);

	logic [15:0] train_freq_q;
	logic [8:0]  beeps_left_q;
	logic        phase_q;
	logic [7:0]  tick_count_q;

	logic [15:0] train_freq_d;
	logic [8:0]  beeps_left_d;
	logic        phase_d;
	logic [7:0]  tick_count_d;
	logic [7:0]  tick_inc;
	tone_lookup_t lk;

	assign lk       = tone_table(item.kind);
	assign tick_inc = tick_count_q + 8'd1;

	// Next state and result for the item in stage one
	always_comb begin
		train_freq_d = train_freq_q;
		beeps_left_d = beeps_left_q;
		phase_d      = phase_q;
		tick_count_d = tick_count_q;
		res_valid    = 1'b0;
		res          = lk.tone;
		if (item.cmd == CMD_EVENT) begin
			if (item.kind == KIND_SLOT) begin
				if (beeps_left_q == '0) begin
					train_freq_d = 16'(TRAIN_BASE_HZ) + 16'(TRAIN_STEP_HZ) * {8'd0, item.param};
					beeps_left_d = {1'b0, item.param} + 9'd1;
					phase_d      = 1'b0;
					tick_count_d = '0;
				end
			end else begin
				res_valid = lk.hit;
			end
		end else if (beeps_left_q != '0) begin
			if (!phase_q) begin
				// emit phase: one beep command
				res_valid = 1'b1;
				res       = '{train_freq_q, 12'(BEEP_ON_MS)};
				phase_d   = 1'b1;
			end else if (tick_inc > WAIT_LIMIT) begin
				// end of the beep period
				beeps_left_d = beeps_left_q - 9'd1;
				phase_d      = 1'b0;
				tick_count_d = '0;
			end else begin
				tick_count_d = tick_inc;
			end
		end
	end

	// Train state, updated as each item leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_freq_q <= '0;
			beeps_left_q <= '0;
			phase_q      <= 1'b0;
			tick_count_q <= '0;
		end else if (step) begin
			train_freq_q <= train_freq_d;
			beeps_left_q <= beeps_left_d;
			phase_q      <= phase_d;
			tick_count_q <= tick_count_d;
		end
	end

endmodule

// ===== hdl/beep_pattern_sequencer.sv =====
// Top level of the beep pattern sequencer: input register, step logic, result register.
//
// Usage:
//   ev channel (ev_valid / ev_stall / ev) carries items: a tick (cmd 0) of
//   TICK_MS milliseconds or a tone event (cmd 1) with a kind and a param.
//   tone channel (tone_valid / tone_stall / tone) carries tone commands:
//   frequency in Hz and duration in ms. An item gives zero or one command.
//   An item is taken at a rising edge with valid high and stall low.
// Order: an item taken sits in the input register; its command, if any, is
//   registered into the result register when stage one advances past it.
// Throughput: one item per cycle unless the receiver stalls; train state and
//   tone table are a single level of logic between input and result registers.
// Stall: while the receiver stalls with a command waiting, the item in the
//   input register is held and ev_stall is raised; nothing is dropped.
// Reset: arst_n clears both registers' valid flags and the train state (no
//   train running, emit phase, tick count zero).
module beep_pattern_sequencer import bps_pkg::*; #(
	parameter int TICK_MS = TICK_MS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ev_valid,
	output logic       ev_stall,
	input  ev_item_t   ev,
	output logic       tone_valid,
	input  logic       tone_stall,
	output tone_item_t tone
);

	logic       valid_s1;
	ev_item_t   item_s1;
	logic       advance;
	logic       res_valid;
	tone_item_t res;
	logic       tone_valid_q;
	tone_item_t tone_q;

	// Stage one moves on when it holds an item, unless a waiting command is stalled
	assign advance  = valid_s1 && !(tone_valid_q && tone_stall);
	assign ev_stall = valid_s1 && tone_valid_q && tone_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!ev_stall) begin
			valid_s1 <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && !ev_stall) begin
			item_s1 <= ev;
		end
	end

	bps_core #(
		.TICK_MS(TICK_MS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_valid_q <= 1'b0;
		end else if (advance) begin
			tone_valid_q <= res_valid;
		end else if (!tone_stall) begin
			tone_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			tone_q <= res;
		end
	end

	assign tone_valid = tone_valid_q;
	assign tone       = tone_q;

endmodule
